@@ hw/rtl/ltbr_pkg.sv @@
// ----------------------------------------------------------------------------
// ltbr_pkg: shared types and constants for the light to backlight ramp
// Field widths, register indexes and reset values, fixed-point widths
// of the ramp, and the control structs between the sequencer and the divider.
// ----------------------------------------------------------------------------
package ltbr_pkg;

   // Field widths
   localparam int LEVEL_W        = 16;
   localparam int LIGHT_W        = 16;
   localparam int STEPS_W        = 7;
   localparam int ENABLE_W       = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   // Ramp limits and level range
   localparam int MAX_RAMP_STEPS = 64;
   localparam int LEVEL_BITS     = 16;
   localparam int LEVEL_MAX      = (1 << LEVEL_BITS) - 1;

   // Fixed-point ramp: Q.16 step, signed step and accumulator
   localparam int FRAC_W         = 16;
   localparam int STEP_W         = LEVEL_W + FRAC_W + 2;
   localparam int ACC_W          = STEP_W + 1;

   // Shared divider geometry
   localparam int DIV_DVD_W      = 2 * LEVEL_W + 1;
   localparam int DIV_DSR_W      = LIGHT_W;
   localparam int DIV_STEPS      = DIV_DVD_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CFG_DARK_LIGHT        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_BRIGHT_LIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_DARK_BACKLIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_BRIGHT_BACKLIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_DARK_KEYBOARD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_BRIGHT_KEYBOARD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_RAMP_STEPS        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CFG_CHANNEL_ENABLE    = 3'd7;

   // Reset values
   localparam logic [LIGHT_W-1:0]  RST_DARK_LIGHT        = 16'd0;
   localparam logic [LIGHT_W-1:0]  RST_BRIGHT_LIGHT      = 16'd1000;
   localparam logic [LEVEL_W-1:0]  RST_DARK_BACKLIGHT    = 16'd0;
   localparam logic [LEVEL_W-1:0]  RST_BRIGHT_BACKLIGHT  = 16'hFFFF;
   localparam logic [LEVEL_W-1:0]  RST_DARK_KEYBOARD     = 16'd0;
   localparam logic [LEVEL_W-1:0]  RST_BRIGHT_KEYBOARD   = 16'd0;
   localparam logic [STEPS_W-1:0]  RST_RAMP_STEPS        = 7'd1;
   localparam logic [ENABLE_W-1:0] RST_CHANNEL_ENABLE    = 2'd3;

   // Configuration register set
   typedef struct packed {
      logic [LIGHT_W-1:0]  dark_light;
      logic [LIGHT_W-1:0]  bright_light;
      logic [LEVEL_W-1:0]  dark_backlight_level;
      logic [LEVEL_W-1:0]  bright_backlight_level;
      logic [LEVEL_W-1:0]  dark_keyboard_level;
      logic [LEVEL_W-1:0]  bright_keyboard_level;
      logic [STEPS_W-1:0]  ramp_steps;
      logic [ENABLE_W-1:0] channel_enable;
   } cfg_type;

   // Divider command
   typedef struct packed {
      logic                 start;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DSR_W-1:0] divisor;
   } div_req_type;

   // Divider result
   typedef struct packed {
      logic                 done;
      logic [DIV_DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ hw/rtl/ltbr_if.sv @@
// ----------------------------------------------------------------------------
// ltbr_if: channel interfaces of the light to backlight ramp
// Input item channel, result item channel and register write channel,
// each a valid/ready handshake with source and sink views.
// ----------------------------------------------------------------------------

// Input item: light reading and present levels
interface ltbr_req_if;
   logic                        valid;
   logic                        ready;
   logic [ltbr_pkg::LIGHT_W-1:0] light_level;
   logic [ltbr_pkg::LEVEL_W-1:0] present_backlight;
   logic [ltbr_pkg::LEVEL_W-1:0] current_keyboard;

   modport source (output valid, light_level, present_backlight, current_keyboard,
                   input ready);
   modport sink   (input valid, light_level, present_backlight, current_keyboard,
                   output ready);
endinterface

// Result item: one ramp step
interface ltbr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ltbr_pkg::LEVEL_W-1:0] backlight_level;
   logic [ltbr_pkg::LEVEL_W-1:0] keyboard_level;
   logic                        backlight_valid;
   logic                        keyboard_valid;
   logic                        last_of_run;

   modport source (output valid, backlight_level, keyboard_level, backlight_valid,
                   keyboard_valid, last_of_run, input ready);
   modport sink   (input valid, backlight_level, keyboard_level, backlight_valid,
                   keyboard_valid, last_of_run, output ready);
endinterface

// Register write channel
interface ltbr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ltbr_pkg::CSR_IDX_W-1:0]  index;
   logic [ltbr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ltbr_csr.sv @@
// ----------------------------------------------------------------------------
// ltbr_csr: configuration registers
// Holds the eight ramp settings; a write lands at the edge where the
// write channel handshakes. Ready whenever reset is low.
// ----------------------------------------------------------------------------
module ltbr_csr (
   input  logic              clock,
   input  logic              reset,
   ltbr_csr_if.sink          csr_ch,
   output ltbr_pkg::cfg_type cfg
);

   ltbr_pkg::cfg_type cfg_ff;
   ltbr_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_ch.ready = !reset;
   assign wr_en        = csr_ch.valid;
   assign cfg          = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_ch.index)
            ltbr_pkg::CFG_DARK_LIGHT:       cfg_in.dark_light = csr_ch.data;
            ltbr_pkg::CFG_BRIGHT_LIGHT:     cfg_in.bright_light = csr_ch.data;
            ltbr_pkg::CFG_DARK_BACKLIGHT:   cfg_in.dark_backlight_level = csr_ch.data;
            ltbr_pkg::CFG_BRIGHT_BACKLIGHT: cfg_in.bright_backlight_level = csr_ch.data;
            ltbr_pkg::CFG_DARK_KEYBOARD:    cfg_in.dark_keyboard_level = csr_ch.data;
            ltbr_pkg::CFG_BRIGHT_KEYBOARD:  cfg_in.bright_keyboard_level = csr_ch.data;
            ltbr_pkg::CFG_RAMP_STEPS:
               cfg_in.ramp_steps = csr_ch.data[ltbr_pkg::STEPS_W-1:0];
            ltbr_pkg::CFG_CHANNEL_ENABLE:
               cfg_in.channel_enable = csr_ch.data[ltbr_pkg::ENABLE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_light             <= ltbr_pkg::RST_DARK_LIGHT;
         cfg_ff.bright_light           <= ltbr_pkg::RST_BRIGHT_LIGHT;
         cfg_ff.dark_backlight_level   <= ltbr_pkg::RST_DARK_BACKLIGHT;
         cfg_ff.bright_backlight_level <= ltbr_pkg::RST_BRIGHT_BACKLIGHT;
         cfg_ff.dark_keyboard_level    <= ltbr_pkg::RST_DARK_KEYBOARD;
         cfg_ff.bright_keyboard_level  <= ltbr_pkg::RST_BRIGHT_KEYBOARD;
         cfg_ff.ramp_steps             <= ltbr_pkg::RST_RAMP_STEPS;
         cfg_ff.channel_enable         <= ltbr_pkg::RST_CHANNEL_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/ltbr_div.sv @@
// ----------------------------------------------------------------------------
// ltbr_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle. A start loads the
// operands; done pulses for one cycle once the quotient register is final.
// ----------------------------------------------------------------------------
module ltbr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ltbr_pkg::div_req_type div_req,
   output ltbr_pkg::div_rsp_type div_rsp
);

   localparam int DVD_W = ltbr_pkg::DIV_DVD_W;
   localparam int DSR_W = ltbr_pkg::DIV_DSR_W;
   localparam int CNT_W = ltbr_pkg::DIV_CNT_W;

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [DSR_W:0]   rem_sh;
   logic [DSR_W+1:0] trial;
   logic             fits;

   // One restoring step: shift in next dividend bit, try subtract
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dsr_ff};
   assign fits   = ~trial[DSR_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
         cnt_in = CNT_W'(ltbr_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ hw/rtl/light_to_backlight_ramp.sv @@
// ----------------------------------------------------------------------------
// light_to_backlight_ramp: ambient light to screen and keyboard ramp
// Maps a light reading to target levels by clamped linear interpolation,
// then emits ramp_steps (clamped to 1..64) Q.16 ramp points from the present levels.
// ----------------------------------------------------------------------------
//
//  channel  role     handshake       payload
//  req_ch   in       valid/ready     light_level, present_backlight, current_keyboard
//  rsp_ch   out      valid/ready     backlight_level, keyboard_level, backlight_valid,
//                                    keyboard_valid, last_of_run
//  csr_ch   in       valid/ready     index (3b), data (16b); ready outside reset
//
//  One item at a time: after the accept, each channel in turn (screen, then
//  keyboard) passes MUL_A and MUL_B, two divider starts and two divider passes
//  (target, then step); ramp points then leave one per cycle while rsp_ch is ready.
//  req_ch.ready is high only between items; the last result may still wait
//  in the output register while the next item is taken.
//  rsp_ch back-pressure stalls the ramp. Reset is synchronous, active high.
//
module light_to_backlight_ramp (
   input  logic       clock,
   input  logic       reset,
   ltbr_req_if.sink   req_ch,
   ltbr_rsp_if.source rsp_ch,
   ltbr_csr_if.sink   csr_ch
);

   localparam int LEVEL_W = ltbr_pkg::LEVEL_W;
   localparam int LIGHT_W = ltbr_pkg::LIGHT_W;
   localparam int STEPS_W = ltbr_pkg::STEPS_W;
   localparam int FRAC_W  = ltbr_pkg::FRAC_W;
   localparam int STEP_W  = ltbr_pkg::STEP_W;
   localparam int ACC_W   = ltbr_pkg::ACC_W;
   localparam int DVD_W   = ltbr_pkg::DIV_DVD_W;
   localparam int DSR_W   = ltbr_pkg::DIV_DSR_W;
   localparam int PROD_W  = LEVEL_W + LIGHT_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MUL_A   = 3'd1;
   localparam logic [2:0] ST_MUL_B   = 3'd2;
   localparam logic [2:0] ST_START_T = 3'd3;
   localparam logic [2:0] ST_WAIT_T  = 3'd4;
   localparam logic [2:0] ST_DIFF    = 3'd5;
   localparam logic [2:0] ST_WAIT_S  = 3'd6;
   localparam logic [2:0] ST_RAMP    = 3'd7;

   // Saturate a Q.16 accumulator to the level range
   function automatic logic [LEVEL_W-1:0] sat_level(input logic [ACC_W-1:0] acc);
      logic [ACC_W-FRAC_W-1:0] whole;
      whole = acc[ACC_W-1:FRAC_W];
      if (acc[ACC_W-1])
         return '0;
      else if (whole > (ACC_W-FRAC_W)'(ltbr_pkg::LEVEL_MAX))
         return LEVEL_W'(ltbr_pkg::LEVEL_MAX);
      else
         return whole[LEVEL_W-1:0];
   endfunction

   ltbr_pkg::cfg_type     cfg;
   ltbr_pkg::div_req_type div_req;
   ltbr_pkg::div_rsp_type div_rsp;

   logic [2:0]          state_ff, state_in;
   logic                ch_ff, ch_in;
   logic [STEPS_W-1:0]  k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [LIGHT_W-1:0]  light_ff;
   logic [LEVEL_W-1:0]  cur_b_ff, cur_k_ff;
   logic [PROD_W-1:0]   prod_a_ff, prod_b_ff;
   logic [LEVEL_W-1:0]  target_ff;
   logic                neg_ff;
   logic [STEP_W-1:0]   step_b_ff, step_k_ff;
   logic [ACC_W-1:0]    acc_b_ff, acc_k_ff;
   logic [LEVEL_W-1:0]  out_b_ff, out_k_ff;
   logic                out_bv_ff, out_kv_ff, out_last_ff;

   logic                accept;
   logic                out_free;
   logic                fire;
   logic                last_step;
   logic                en_b, en_k;
   logic [STEPS_W-1:0]  n_eff;
   logic [LEVEL_W-1:0]  lo_lvl, hi_lvl, cur_lvl;
   logic [LEVEL_W-1:0]  mul_a;
   logic [LIGHT_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [LEVEL_W-1:0]  target_sel;
   logic [LEVEL_W:0]    diff;
   logic [LEVEL_W:0]    mag;
   logic [STEP_W-1:0]   step_new;
   logic [ACC_W-1:0]    acc_init;
   logic [ACC_W-1:0]    acc_b_nx, acc_k_nx;

   ltbr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ltbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Channel enables and effective step count
   assign en_b = cfg.channel_enable[0];
   assign en_k = cfg.channel_enable[1];

   always_comb begin
      if (cfg.ramp_steps == '0)
         n_eff = STEPS_W'(1);
      else if (cfg.ramp_steps > STEPS_W'(ltbr_pkg::MAX_RAMP_STEPS))
         n_eff = STEPS_W'(ltbr_pkg::MAX_RAMP_STEPS);
      else
         n_eff = cfg.ramp_steps;
   end

   // Per-channel operand select
   assign lo_lvl  = ch_ff ? cfg.dark_keyboard_level   : cfg.dark_backlight_level;
   assign hi_lvl  = ch_ff ? cfg.bright_keyboard_level : cfg.bright_backlight_level;
   assign cur_lvl = ch_ff ? cur_k_ff : cur_b_ff;

   // Shared multiplier: dark*(bright_light-x), then bright*(x-dark_light)
   assign mul_a = (state_ff == ST_MUL_A) ? lo_lvl : hi_lvl;
   assign mul_b = (state_ff == ST_MUL_A) ? (cfg.bright_light - light_ff)
                                         : (light_ff - cfg.dark_light);
   assign mul_p = mul_a * mul_b;

   // Clamp or interpolate
   always_comb begin
      if (light_ff <= cfg.dark_light)
         target_sel = lo_lvl;
      else if (light_ff >= cfg.bright_light)
         target_sel = hi_lvl;
      else
         target_sel = div_rsp.quotient[LEVEL_W-1:0];
   end

   // Signed difference and its magnitude
   assign diff = {1'b0, target_ff} - {1'b0, cur_lvl};
   assign mag  = diff[LEVEL_W] ? (~diff + 1'b1) : diff;

   // Step restored to its sign; accumulator starts at current level
   assign step_new = neg_ff ? (~{1'b0, div_rsp.quotient} + 1'b1)
                            : {1'b0, div_rsp.quotient};
   assign acc_init = {{(ACC_W-LEVEL_W-FRAC_W){1'b0}}, cur_lvl, {FRAC_W{1'b0}}};

   // Divider commands
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      if (state_ff == ST_START_T) begin
         div_req.start    = 1'b1;
         div_req.dividend = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
         div_req.divisor  = cfg.bright_light - cfg.dark_light;
      end else if (state_ff == ST_DIFF) begin
         div_req.start    = 1'b1;
         div_req.dividend = {{(DVD_W-LEVEL_W-FRAC_W){1'b0}}, mag[LEVEL_W-1:0],
                             {FRAC_W{1'b0}}};
         div_req.divisor  = {{(DSR_W-STEPS_W){1'b0}}, n_eff};
      end
   end

   // Ramp stepping and output register handshake
   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign fire      = (state_ff == ST_RAMP) && out_free;
   assign last_step = (k_ff == n_eff);
   assign acc_b_nx  = acc_b_ff + {step_b_ff[STEP_W-1], step_b_ff};
   assign acc_k_nx  = acc_k_ff + {step_k_ff[STEP_W-1], step_k_ff};

   // Sequencer
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in    = 1'b0;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A:   state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_START_T;
         ST_START_T: state_in = ST_WAIT_T;
         ST_WAIT_T: begin
            if (div_rsp.done)
               state_in = ST_DIFF;
         end
         ST_DIFF:    state_in = ST_WAIT_S;
         ST_WAIT_S: begin
            if (div_rsp.done) begin
               if (ch_ff) begin
                  k_in     = STEPS_W'(1);
                  state_in = ST_RAMP;
               end else begin
                  ch_in    = 1'b1;
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_RAMP: begin
            if (fire) begin
               k_in = k_ff + 1'b1;
               if (last_step)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         light_ff <= req_ch.light_level;
         cur_b_ff <= req_ch.present_backlight;
         cur_k_ff <= req_ch.current_keyboard;
      end
      if (state_ff == ST_MUL_A)
         prod_a_ff <= mul_p;
      if (state_ff == ST_MUL_B)
         prod_b_ff <= mul_p;
      if (state_ff == ST_WAIT_T && div_rsp.done)
         target_ff <= target_sel;
      if (state_ff == ST_DIFF)
         neg_ff <= diff[LEVEL_W];
      if (state_ff == ST_WAIT_S && div_rsp.done) begin
         if (ch_ff) begin
            step_k_ff <= step_new;
            acc_k_ff  <= acc_init;
         end else begin
            step_b_ff <= step_new;
            acc_b_ff  <= acc_init;
         end
      end
      if (fire) begin
         acc_b_ff    <= acc_b_nx;
         acc_k_ff    <= acc_k_nx;
         out_b_ff    <= en_b ? sat_level(acc_b_nx) : '0;
         out_k_ff    <= en_k ? sat_level(acc_k_nx) : '0;
         out_bv_ff   <= en_b;
         out_kv_ff   <= en_k;
         out_last_ff <= last_step;
      end
   end

   // Ports
   assign req_ch.ready           = (state_ff == ST_IDLE) && !reset;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.backlight_level = out_b_ff;
   assign rsp_ch.keyboard_level  = out_k_ff;
   assign rsp_ch.backlight_valid = out_bv_ff;
   assign rsp_ch.keyboard_valid  = out_kv_ff;
   assign rsp_ch.last_of_run     = out_last_ff;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for light_to_backlight_ramp
// Drives light readings with present screen and keyboard levels, predicts
// every ramp point from a local model of the target map and the Q.16 ramp,
// and checks each result item in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    LEVEL_W        = ltbr_pkg::LEVEL_W;
   localparam int    LIGHT_W        = ltbr_pkg::LIGHT_W;
   localparam int    FRAC_W         = ltbr_pkg::FRAC_W;
   localparam int    STEPS_W        = ltbr_pkg::STEPS_W;
   localparam int    ENABLE_W       = ltbr_pkg::ENABLE_W;
   localparam int    CSR_IDX_W      = ltbr_pkg::CSR_IDX_W;
   localparam int    CSR_DATA_W     = ltbr_pkg::CSR_DATA_W;
   localparam int    LEVEL_MAX      = ltbr_pkg::LEVEL_MAX;
   localparam int    MAX_RAMP_STEPS = ltbr_pkg::MAX_RAMP_STEPS;

   localparam int    CLK_PERIOD    = 20;
   localparam int    RESET_CYCLES  = 11;
   localparam int    IDLE_SETTLE   = 20;    // quiet cycles before a register write
   localparam int    END_SETTLE    = 300;   // about one full item with the longest ramp
   localparam int    HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int    PRINT_CAP     = 100;
   localparam longint RUN_LIMIT_NS = 30_000_000;

   // One expected ramp point
   typedef struct packed {
      logic [LEVEL_W-1:0] backlight_level;
      logic [LEVEL_W-1:0] keyboard_level;
      logic               backlight_valid;
      logic               keyboard_valid;
      logic               last_of_run;
   } ramp_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ltbr_req_if req_ch ();
   ltbr_rsp_if rsp_ch ();
   ltbr_csr_if csr_ch ();

   light_to_backlight_ramp dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Local copy of the register set, updated on each accepted write
   ltbr_pkg::cfg_type shadow_cfg = '{
      dark_light:             ltbr_pkg::RST_DARK_LIGHT,
      bright_light:           ltbr_pkg::RST_BRIGHT_LIGHT,
      dark_backlight_level:   ltbr_pkg::RST_DARK_BACKLIGHT,
      bright_backlight_level: ltbr_pkg::RST_BRIGHT_BACKLIGHT,
      dark_keyboard_level:    ltbr_pkg::RST_DARK_KEYBOARD,
      bright_keyboard_level:  ltbr_pkg::RST_BRIGHT_KEYBOARD,
      ramp_steps:             ltbr_pkg::RST_RAMP_STEPS,
      channel_enable:         ltbr_pkg::RST_CHANNEL_ENABLE
   };

   ramp_point_type pending_points[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   int mismatch_count  = 0;
   int readings_sent   = 0;
   int points_checked  = 0;
   int settings_loaded = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Timeout guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Clamped linear map of the light reading onto one channel's levels
   function automatic logic [LEVEL_W-1:0] map_light(input logic [LIGHT_W-1:0] light,
                                                     input logic [LEVEL_W-1:0] lo_lvl,
                                                     input logic [LEVEL_W-1:0] hi_lvl);
      longint span;
      longint num;
      if (light <= shadow_cfg.dark_light) return lo_lvl;
      if (light >= shadow_cfg.bright_light) return hi_lvl;
      span = longint'(shadow_cfg.bright_light) - longint'(shadow_cfg.dark_light);
      num  = longint'(lo_lvl) * (longint'(shadow_cfg.bright_light) - longint'(light)) +
             longint'(hi_lvl) * (longint'(light) - longint'(shadow_cfg.dark_light));
      return LEVEL_W'(num / span);
   endfunction

   // Point k of an n-step ramp; the Q.16 step truncates toward zero
   function automatic logic [LEVEL_W-1:0] ramp_level(input logic [LEVEL_W-1:0] cur,
                                                      input logic [LEVEL_W-1:0] tgt,
                                                      input int k, input int n);
      longint diff;
      longint stride;
      longint acc;
      longint lvl;
      diff   = longint'(tgt) - longint'(cur);
      stride = (diff * (longint'(1) << FRAC_W)) / longint'(n);
      acc    = (longint'(cur) << FRAC_W) + longint'(k) * stride;
      if (acc < 0) return '0;
      lvl = acc >> FRAC_W;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      return LEVEL_W'(lvl);
   endfunction

   // Queue every ramp point that one accepted reading causes
   task automatic predict_ramp(input logic [LIGHT_W-1:0] light,
                               input logic [LEVEL_W-1:0] cur_b,
                               input logic [LEVEL_W-1:0] cur_k);
      int             n;
      logic           en_b;
      logic           en_k;
      logic [LEVEL_W-1:0] tgt_b;
      logic [LEVEL_W-1:0] tgt_k;
      ramp_point_type pt;
      n    = shadow_cfg.ramp_steps;
      if (n < 1) n = 1;
      if (n > MAX_RAMP_STEPS) n = MAX_RAMP_STEPS;
      en_b  = shadow_cfg.channel_enable[0];
      en_k  = shadow_cfg.channel_enable[1];
      tgt_b = en_b ? map_light(light, shadow_cfg.dark_backlight_level,
                               shadow_cfg.bright_backlight_level) : '0;
      tgt_k = en_k ? map_light(light, shadow_cfg.dark_keyboard_level,
                               shadow_cfg.bright_keyboard_level) : '0;
      for (int k = 1; k <= n; k++) begin
         pt.backlight_level = en_b ? ramp_level(cur_b, tgt_b, k, n) : '0;
         pt.keyboard_level  = en_k ? ramp_level(cur_k, tgt_k, k, n) : '0;
         pt.backlight_valid = en_b;
         pt.keyboard_valid  = en_k;
         pt.last_of_run     = (k == n);
         pending_points.push_back(pt);
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t ns  mismatch: %s", $realtime, what);
   endtask

   // Compare each accepted result item with the oldest expected point
   always @(posedge clock) begin : check_points
      ramp_point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("result item with nothing expected (bl %0d kb %0d)",
                                      rsp_ch.backlight_level, rsp_ch.keyboard_level));
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_ch.backlight_level !== want.backlight_level)
               report_mismatch($sformatf("backlight_level %0d, want %0d",
                                         rsp_ch.backlight_level, want.backlight_level));
            if (rsp_ch.keyboard_level !== want.keyboard_level)
               report_mismatch($sformatf("keyboard_level %0d, want %0d",
                                         rsp_ch.keyboard_level, want.keyboard_level));
            if (rsp_ch.backlight_valid !== want.backlight_valid)
               report_mismatch($sformatf("backlight_valid %b, want %b",
                                         rsp_ch.backlight_valid, want.backlight_valid));
            if (rsp_ch.keyboard_valid !== want.keyboard_valid)
               report_mismatch($sformatf("keyboard_valid %b, want %b",
                                         rsp_ch.keyboard_valid, want.keyboard_valid));
            if (rsp_ch.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %b, want %b",
                                         rsp_ch.last_of_run, want.last_of_run));
         end
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one reading; valid is left high so back-to-back items need no drop
   task automatic send_reading(input logic [LIGHT_W-1:0] light,
                               input logic [LEVEL_W-1:0] cur_b,
                               input logic [LEVEL_W-1:0] cur_k);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.light_level       <= light;
      req_ch.present_backlight <= cur_b;
      req_ch.current_keyboard  <= cur_k;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_ramp(light, cur_b, cur_k);
      readings_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected point has come back
   task automatic wait_drain(input int settle);
      req_ch.valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         ltbr_pkg::CFG_DARK_LIGHT:       shadow_cfg.dark_light             = val;
         ltbr_pkg::CFG_BRIGHT_LIGHT:     shadow_cfg.bright_light           = val;
         ltbr_pkg::CFG_DARK_BACKLIGHT:   shadow_cfg.dark_backlight_level   = val;
         ltbr_pkg::CFG_BRIGHT_BACKLIGHT: shadow_cfg.bright_backlight_level = val;
         ltbr_pkg::CFG_DARK_KEYBOARD:    shadow_cfg.dark_keyboard_level    = val;
         ltbr_pkg::CFG_BRIGHT_KEYBOARD:  shadow_cfg.bright_keyboard_level  = val;
         ltbr_pkg::CFG_RAMP_STEPS:       shadow_cfg.ramp_steps = val[STEPS_W-1:0];
         ltbr_pkg::CFG_CHANNEL_ENABLE:   shadow_cfg.channel_enable = val[ENABLE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Load a full register set; narrow registers get random upper data bits
   task automatic program_regs(input ltbr_pkg::cfg_type c);
      logic [CSR_DATA_W-1:0] pad;
      pad = CSR_DATA_W'($urandom);
      write_reg(ltbr_pkg::CFG_DARK_LIGHT,       c.dark_light);
      write_reg(ltbr_pkg::CFG_BRIGHT_LIGHT,     c.bright_light);
      write_reg(ltbr_pkg::CFG_DARK_BACKLIGHT,   c.dark_backlight_level);
      write_reg(ltbr_pkg::CFG_BRIGHT_BACKLIGHT, c.bright_backlight_level);
      write_reg(ltbr_pkg::CFG_DARK_KEYBOARD,    c.dark_keyboard_level);
      write_reg(ltbr_pkg::CFG_BRIGHT_KEYBOARD,  c.bright_keyboard_level);
      write_reg(ltbr_pkg::CFG_RAMP_STEPS,
                {pad[CSR_DATA_W-1:STEPS_W], c.ramp_steps});
      write_reg(ltbr_pkg::CFG_CHANNEL_ENABLE,
                {pad[CSR_DATA_W-1:ENABLE_W], c.channel_enable});
      csr_ch.valid <= 1'b0;
      settings_loaded++;
   endtask

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic ltbr_pkg::cfg_type rand_config();
      ltbr_pkg::cfg_type c;
      logic [15:0]       tmp;
      c.dark_light   = rand_word();
      c.bright_light = rand_word();
      // mostly ordered thresholds, sometimes a very narrow window
      if ($urandom_range(0, 4) != 0 && c.dark_light > c.bright_light) begin
         tmp            = c.dark_light;
         c.dark_light   = c.bright_light;
         c.bright_light = tmp;
      end
      if ($urandom_range(0, 5) == 0 && c.dark_light < 16'hFFF0)
         c.bright_light = c.dark_light + 16'($urandom_range(1, 3));
      c.dark_backlight_level   = rand_word();
      c.bright_backlight_level = rand_word();
      c.dark_keyboard_level    = rand_word();
      c.bright_keyboard_level  = rand_word();
      // short ramps mostly, a few long or out of range
      case ($urandom_range(0, 9))
         0:       c.ramp_steps = '0;
         1:       c.ramp_steps = STEPS_W'($urandom_range(65, 127));
         2, 3:    c.ramp_steps = STEPS_W'($urandom_range(9, 64));
         default: c.ramp_steps = STEPS_W'($urandom_range(1, 8));
      endcase
      c.channel_enable = ($urandom_range(0, 2) == 0) ? ENABLE_W'($urandom_range(0, 3))
                                                    : 2'b11;
      return c;
   endfunction

   // Light readings cluster on the thresholds and the range ends
   function automatic logic [15:0] rand_light();
      case ($urandom_range(0, 5))
         0:       return 16'(shadow_cfg.dark_light + $urandom_range(0, 4) - 2);
         1:       return 16'(shadow_cfg.bright_light + $urandom_range(0, 4) - 2);
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Register values straight out of reset
   task automatic test_reset_defaults();
      send_reading(16'd0,     16'd0,     16'hFFFF);
      send_reading(16'd1000,  16'hFFFF,  16'd0);
      send_reading(16'd500,   16'd12345, 16'd54321);
      send_reading(16'hFFFF,  16'hFFFF,  16'hFFFF);
   endtask

   // Readings on and around both thresholds, falling backlight map, rising keyboard map
   task automatic test_clamp_edges();
      ltbr_pkg::cfg_type c;
      c = shadow_cfg;
      c.dark_light             = 16'd100;
      c.bright_light           = 16'd60000;
      c.dark_backlight_level   = 16'hFFFF;
      c.bright_backlight_level = 16'd0;
      c.dark_keyboard_level    = 16'd0;
      c.bright_keyboard_level  = 16'hFFFF;
      c.ramp_steps             = 7'd1;
      c.channel_enable         = 2'b11;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'd99,    16'd0,    16'hFFFF);
      send_reading(16'd100,   16'hFFFF, 16'd0);
      send_reading(16'd101,   16'd0,    16'd0);
      send_reading(16'd30050, 16'hFFFF, 16'hFFFF);
      send_reading(16'd59999, 16'd0,    16'hFFFF);
      send_reading(16'd60000, 16'hFFFF, 16'd0);
   endtask

   // Step count of zero, the maximum, above the maximum, and a flat ramp
   task automatic test_ramp_lengths();
      ltbr_pkg::cfg_type c;
      c = shadow_cfg;
      c.dark_light             = 16'd0;
      c.bright_light           = 16'hFFFF;
      c.dark_backlight_level   = 16'd0;
      c.bright_backlight_level = 16'hFFFF;
      c.dark_keyboard_level    = 16'hFFFF;
      c.bright_keyboard_level  = 16'd0;
      c.ramp_steps             = 7'd0;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'hFFFF, 16'd0, 16'd0);
      c.ramp_steps = 7'(MAX_RAMP_STEPS);
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'hFFFF, 16'd0, 16'hFFFF);
      send_reading(16'd0, 16'hFFFF, 16'd0);
      c.ramp_steps = 7'd127;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'd33333, 16'd7, 16'd65000);
      c.ramp_steps = 7'd7;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'd0, 16'd0, 16'hFFFF);
   endtask

   // Dark threshold at or above the bright one
   task automatic test_inverted_thresholds();
      ltbr_pkg::cfg_type c;
      c = shadow_cfg;
      c.dark_light             = 16'd5000;
      c.bright_light           = 16'd5000;
      c.dark_backlight_level   = 16'd1234;
      c.bright_backlight_level = 16'd40000;
      c.dark_keyboard_level    = 16'd60000;
      c.bright_keyboard_level  = 16'd17;
      c.ramp_steps             = 7'd3;
      c.channel_enable         = 2'b11;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'd5000, 16'd100, 16'd100);
      send_reading(16'd5001, 16'd100, 16'd100);
      c.dark_light   = 16'hFFFF;
      c.bright_light = 16'd0;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_reading(16'hFFFF, 16'd0, 16'hFFFF);
      send_reading(16'd0,    16'hFFFF, 16'd0);
   endtask

   // Neither channel, then each channel alone
   task automatic test_channel_enables();
      ltbr_pkg::cfg_type c;
      c = shadow_cfg;
      c.dark_light   = 16'd10;
      c.bright_light = 16'd20000;
      c.ramp_steps   = 7'd2;
      for (int en = 0; en < 3; en++) begin
         c.channel_enable = ENABLE_W'(en);
         wait_drain(IDLE_SETTLE);
         program_regs(c);
         send_reading(16'd8000, 16'd30000, 16'd5);
      end
   endtask

   // Long receiver hold-off while readings keep coming
   task automatic test_output_backpressure();
      ltbr_pkg::cfg_type c;
      c = rand_config();
      c.ramp_steps     = 7'd5;
      c.channel_enable = 2'b11;
      wait_drain(IDLE_SETTLE);
      program_regs(c);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      for (int i = 0; i < 6; i++)
         send_reading(rand_light(), rand_word(), rand_word());
   endtask

   // Random settings and readings; the sender pauses for a full drain midway
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            wait_drain(IDLE_SETTLE);
            program_regs(rand_config());
         end else if (i == count / 2 + 1) begin
            wait_drain(0);
         end
         send_reading(rand_light(), rand_word(), rand_word());
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid             = 1'b0;
      req_ch.light_level       = '0;
      req_ch.present_backlight = '0;
      req_ch.current_keyboard  = '0;
      csr_ch.valid             = 1'b0;
      csr_ch.index             = '0;
      csr_ch.data              = '0;
      rsp_ch.ready             = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 55;
      test_reset_defaults();
      test_clamp_edges();
      test_ramp_lengths();
      test_inverted_thresholds();
      test_channel_enables();
      test_output_backpressure();
      test_random_traffic(28, 55, 100);
      test_random_traffic(55, 28, 100);
      test_random_traffic(0, 0, 100);
      wait_drain(END_SETTLE);

      $display("Sent %0d light readings over %0d register settings; %0d ramp points checked,",
               readings_sent, settings_loaded, points_checked);
      $display("including clamp edges, inverted thresholds, channel masks and stalls.");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
